// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level, json_string_escaper.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication violated");

`endif

// ===== hw/rtl/jse_pkg.sv =====
// Types, constants and escape functions for the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

  localparam int CAP_W    = 17;
  localparam int BUDGET_W = 16;
  localparam int IDX_W    = 3;

  localparam logic [CAP_W-1:0]    CAP_RESET  = 17'd4096;
  localparam logic [CAP_W-1:0]    CAP_BIG    = 17'd65536;
  localparam logic [BUDGET_W-1:0] BUDGET_MAX = 16'hFFFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] HEX_ALPHA = 8'h57;  // 'a' - 10

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_PAIR,
    KIND_UNI,
    KIND_TERM
  } kind_t;

  // One accepted item that produces output, as handed to the expander.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] b;
  } desc_t;

  // Byte offered by the expander toward the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] b;
    logic       run_last;
    logic       string_end;
  } emit_t;

  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    if (b == CH_QUOTE || b == CH_BSLASH || b == CH_LF || b == CH_CR || b == CH_TAB) begin
      k = KIND_PAIR;
    end else if (b < CH_SPACE) begin
      k = KIND_UNI;
    end else begin
      k = KIND_PLAIN;
    end
    return k;
  endfunction

  function automatic logic [IDX_W-1:0] seq_len(input kind_t k);
    logic [IDX_W-1:0] n;
    unique case (k)
      KIND_PLAIN: n = 3'd1;
      KIND_PAIR:  n = 3'd2;
      KIND_UNI:   n = 3'd6;
      KIND_TERM:  n = 3'd1;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_DIGIT0 + {4'd0, nib};
    end else begin
      c = HEX_ALPHA + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic [7:0] pair_char(input logic [7:0] b);
    logic [7:0] c;
    priority if (b == CH_LF) begin
      c = CH_N;
    end else if (b == CH_CR) begin
      c = CH_R;
    end else if (b == CH_TAB) begin
      c = CH_T;
    end else begin
      c = b;  // quote and backslash repeat themselves
    end
    return c;
  endfunction

  function automatic logic [7:0] seq_byte(input desc_t d, input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (d.kind)
      KIND_PLAIN: c = d.b;
      KIND_TERM:  c = CH_NUL;
      KIND_PAIR:  c = (idx == 3'd0) ? CH_BSLASH : pair_char(d.b);
      KIND_UNI: begin
        unique case (idx)
          3'd0:    c = CH_BSLASH;
          3'd1:    c = CH_U;
          3'd2:    c = CH_DIGIT0;
          3'd3:    c = CH_DIGIT0;
          3'd4:    c = hex_char(d.b[7:4]);
          3'd5:    c = hex_char(d.b[3:0]);
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [BUDGET_W-1:0] budget_from_cap(input logic [CAP_W-1:0] cap);
    logic [BUDGET_W-1:0] r;
    priority if (cap == '0) begin
      r = '0;
    end else if (cap > CAP_BIG) begin
      r = BUDGET_MAX;
    end else begin
      r = cap[BUDGET_W-1:0] - 16'd1;  // cap of 65536 gives 65535
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/jse_budget.sv =====
// Capacity register, per-string budget and truncation state; decides each item's output.
`timescale 1ns / 1ps

module jse_budget (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [jse_pkg::CAP_W-1:0]  cfg_data,
  input  logic                       take,
  input  logic [7:0]                 in_byte,
  output logic                       desc_valid,
  output jse_pkg::desc_t             desc
);
  import jse_pkg::*;

  logic [CAP_W-1:0]    capacity;
  logic [BUDGET_W-1:0] budget_left;
  logic [BUDGET_W-1:0] budget_left_next;
  logic                truncated;
  logic                truncated_next;
  kind_t               kind_in;
  logic [IDX_W-1:0]    len_in;
  logic                fits;

  assign kind_in = classify(in_byte);
  assign len_in  = seq_len(kind_in);
  assign fits    = {{(BUDGET_W-IDX_W){1'b0}}, len_in} <= budget_left;

  always_comb begin
    budget_left_next = budget_left;
    truncated_next   = truncated;
    desc_valid       = 1'b0;
    desc.kind        = KIND_TERM;
    desc.b           = in_byte;
    priority if (in_byte == CH_NUL) begin
      // terminator only if not already sent by a cut
      desc_valid       = !truncated;
      budget_left_next = budget_from_cap(capacity);
      truncated_next   = 1'b0;
    end else if (truncated) begin
      desc_valid = 1'b0;
    end else if (!fits) begin
      desc_valid     = 1'b1;
      truncated_next = 1'b1;
    end else begin
      desc_valid       = 1'b1;
      desc.kind        = kind_in;
      budget_left_next = budget_left - {{(BUDGET_W-IDX_W){1'b0}}, len_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      budget_left <= budget_from_cap(CAP_RESET);
      truncated   <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (take) begin
        budget_left <= budget_left_next;
        truncated   <= truncated_next;
      end
    end
  end

endmodule

// ===== hw/rtl/jse_expand.sv =====
// Holds one item's escape sequence and steps through its bytes, one per cycle while advance is high.
`timescale 1ns / 1ps

module jse_expand (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jse_pkg::desc_t  desc,
  input  logic            advance,
  output jse_pkg::emit_t  emit
);
  import jse_pkg::*;

  logic             busy;
  desc_t            cur;
  logic [IDX_W-1:0] idx;
  logic             at_last;

  assign at_last         = idx == (seq_len(cur.kind) - 3'd1);
  assign emit.valid      = busy;
  assign emit.b          = seq_byte(cur, idx);
  assign emit.run_last   = at_last;
  assign emit.string_end = cur.kind == KIND_TERM;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && advance) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= desc;
    end
  end

endmodule

// ===== hw/rtl/json_string_escaper.sv =====
// JSON string escaper with per-string output budget; top level and output register.
// An accepted byte goes into the sequence register and then into the output register.
// Throughput: one byte per cycle for plain bytes while out_stall is low; an escape
// holds the input while the sequence register emits its 2 or 6 bytes, one a cycle.
// Reset (rst, synchronous): capacity 4096, budget 4095, not truncated, output empty.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module json_string_escaper (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [jse_pkg::CAP_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      run_last,
  output logic                      string_end
);
  import jse_pkg::*;

  logic   out_load;
  logic   free;
  logic   take;
  logic   desc_valid;
  desc_t  desc;
  emit_t  emit;

  assign out_load = !out_valid || !out_stall;
  // expander can take a new item when empty or when its last byte leaves now
  assign free     = !emit.valid || (emit.run_last && out_load);
  assign in_stall = !free;
  assign take     = in_valid && free;

  jse_budget u_budget (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .take       (take),
    .in_byte    (in_byte),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  jse_expand u_expand (
    .clk     (clk),
    .rst     (rst),
    .load    (take && desc_valid),
    .desc    (desc),
    .advance (out_load),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte   <= emit.b;
      run_last   <= emit.run_last;
      string_end <= emit.string_end;
    end
  end

  `ASSERT_IMP(a_term_shape, clk, rst, out_valid && string_end, out_byte == CH_NUL && run_last)
  `ASSERT_IMP(a_stall_only_busy, clk, rst, in_stall, emit.valid && !(emit.run_last && out_load))
  `ASSERT_NEXT(a_escape_continues, clk, rst, emit.valid && !emit.run_last, emit.valid)

endmodule

// ===== verif/tb_json_string_escaper.sv =====
// Self-checking testbench for json_string_escaper: escapes, output budget, truncation.
`timescale 1ns / 1ps

module tb_json_string_escaper;
  import jse_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       term;
  } esc_byte_t;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             cfg_we     = 1'b0;
  logic [CAP_W-1:0] cfg_data   = '0;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte    = '0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic [7:0]       out_byte;
  logic             run_last;
  logic             string_end;

  // expected escaped bytes, oldest first
  esc_byte_t escaped_q[$];

  // predictor state
  logic [CAP_W-1:0]    model_cap = CAP_RESET;
  logic [BUDGET_W-1:0] model_budget;
  logic                model_cut = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_items     = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  json_string_escaper u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [BUDGET_W-1:0] budget_for(input logic [CAP_W-1:0] cap);
    if (cap == '0) begin
      return '0;
    end
    if (cap > CAP_BIG) begin
      return BUDGET_MAX;
    end
    return BUDGET_W'(cap - 1);
  endfunction

  // Returns the number of escaped bytes the item causes.
  function automatic int predict_escape(input logic [7:0] b);
    logic [7:0] seq [6];
    int         len;
    int         n;
    string      hex;
    n = 0;
    if (b == CH_NUL) begin
      // terminator already sent if the string was cut
      if (!model_cut) begin
        escaped_q.push_back('{CH_NUL, 1'b1, 1'b1});
        n = 1;
      end
      model_budget = budget_for(model_cap);
      model_cut = 1'b0;
      return n;
    end
    if (model_cut) begin
      return 0;
    end
    seq[0] = CH_BSLASH;
    len = 2;
    case (b)
      CH_QUOTE, CH_BSLASH: seq[1] = b;
      CH_LF:               seq[1] = CH_N;
      CH_CR:               seq[1] = CH_R;
      CH_TAB:              seq[1] = CH_T;
      default: begin
        if (b < CH_SPACE) begin
          hex = $sformatf("%02h", b);
          seq[1] = CH_U;
          seq[2] = CH_DIGIT0;
          seq[3] = CH_DIGIT0;
          seq[4] = hex[0];
          seq[5] = hex[1];
          len = 6;
        end else begin
          seq[0] = b;
          len = 1;
        end
      end
    endcase
    if (len > model_budget) begin
      escaped_q.push_back('{CH_NUL, 1'b1, 1'b1});
      model_cut = 1'b1;
      return 1;
    end
    for (int k = 0; k < len; k++) begin
      escaped_q.push_back('{seq[k], (k == len - 1), 1'b0});
    end
    model_budget = model_budget - BUDGET_W'(len);
    return len;
  endfunction

  // Called at a rising edge; returns at the edge where the item was taken.
  // in_valid stays high so back-to-back items need no extra assignment.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    void'(predict_escape(b));
    sent_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (escaped_q.size() != 0) begin
      @(posedge clk);
    end
    // dropped bytes leave nothing in the queue and produce no output
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_cap = cap;
  endtask

  always @(posedge clk) begin : check_results
    esc_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (escaped_q.size() == 0) begin
        $error("unexpected result: out_byte=%02h run_last=%0b string_end=%0b",
               out_byte, run_last, string_end);
        fail_count++;
      end else begin
        want = escaped_q.pop_front();
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %02h, got %02h", want.ch, out_byte);
          fail_count++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, run_last);
          fail_count++;
        end
        if (string_end !== want.term) begin
          $error("string_end: expected %0b, got %0b", want.term, string_end);
          fail_count++;
        end
      end
    end
  end

  task automatic test_escape_classes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_byte(CH_NUL);  // empty string
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(CH_QUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_TAB);
    send_byte(8'h01);
    send_byte(8'h1A);
    send_byte(8'h1F);
    send_byte(CH_NUL);
  endtask

  task automatic test_truncation();
    write_capacity(17'd4);
    send_byte(CH_NUL);  // reload to a budget of 3
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(CH_QUOTE);  // pair does not fit in one byte left
    send_byte(8'h42);     // dropped
    send_byte(CH_NUL);    // no terminator, already sent
  endtask

  task automatic test_capacity_limits();
    write_capacity('0);
    send_byte(CH_NUL);
    send_byte(8'h41);     // zero budget cuts at once
    send_byte(CH_NUL);
    write_capacity({CAP_W{1'b1}});
    send_byte(CH_NUL);
    send_byte(8'h7F);
    send_byte(CH_NUL);
  endtask

  task automatic test_random_strings(input int idle_pct, input int stall_p, input int target);
    int         goal;
    int         len;
    int         pick;
    logic [7:0] b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_p;
    goal = sent_items + target;
    while (sent_items < goal) begin
      if ($urandom_range(3) == 0) begin
        pick = $urandom_range(9);
        case (pick)
          0:       write_capacity('0);
          6:       write_capacity(CAP_W'($urandom_range(13, 80)));
          7:       write_capacity(CAP_RESET);
          8:       write_capacity(CAP_BIG);
          9:       write_capacity(CAP_W'($urandom_range(0, 17'h1FFFF)));
          default: write_capacity(CAP_W'($urandom_range(1, 12)));
        endcase
      end
      if ($urandom_range(7) == 0) begin
        // noise: any byte, zero included, string may be left open
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(0, 10);
        repeat (len) begin
          pick = $urandom_range(9);
          if (pick < 6) begin
            b = 8'($urandom_range(32, 255));
          end else if (pick < 8) begin
            case ($urandom_range(4))
              0:       b = CH_QUOTE;
              1:       b = CH_BSLASH;
              2:       b = CH_LF;
              3:       b = CH_CR;
              default: b = CH_TAB;
            endcase
          end else begin
            b = 8'($urandom_range(1, 31));
          end
          send_byte(b);
        end
        send_byte(CH_NUL);
      end
    end
  endtask

  initial begin
    model_budget = budget_for(CAP_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_escape_classes();
    test_truncation();
    test_capacity_limits();
    test_random_strings(0, 0, 35);
    test_random_strings(55, 0, 40);
    test_random_strings(0, 55, 40);
    test_random_strings(23, 23, 30);
    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
